// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that also holds across reset
`define ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== src/fvsd_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the force vector servo drive
`timescale 1ns / 1ps
package fvsd_pkg;

   localparam logic [2:0] REG_WINDOW  = 3'd0;
   localparam logic [2:0] REG_TURN    = 3'd1;
   localparam logic [2:0] REG_NEUTRAL = 3'd2;
   localparam logic [2:0] REG_MIN     = 3'd3;
   localparam logic [2:0] REG_MAX     = 3'd4;

   localparam logic [16:0] WINDOW_ONE   = 17'd65536;
   localparam logic [16:0] WINDOW_RESET = 17'd32768;
   localparam logic [13:0] TURN_RESET   = 14'd8192;
   localparam logic [7:0]  NEUTRAL_RESET = 8'd128;
   localparam logic [7:0]  MIN_RESET    = 8'd0;
   localparam logic [7:0]  MAX_RESET    = 8'd255;
   localparam logic [7:0]  HIST_RESET   = 8'd128;
   localparam logic [16:0] REV_SCALE    = 17'd52429;
   localparam logic [16:0] FWD_SCALE    = 17'd65536;
   localparam logic signed [16:0] FORCE_LIMIT = 17'sd32768;
   localparam logic [4:0]  CORDIC_LAST  = 5'd27;
   localparam logic [4:0]  SQRT_STEPS   = 5'd16;
   localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
   localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
   localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

   typedef struct packed {
      logic              err;
      logic signed [16:0] x;
      logic signed [16:0] y;
   } item_type;

   typedef struct packed {
      logic [16:0] window;
      logic [13:0] turn;
      logic [7:0]  neutral;
      logic [7:0]  smin;
      logic [7:0]  smax;
   } cfg_type;

   typedef enum logic [3:0] {
      B_IDLE, B_SQ0, B_SQ1, B_ROT, B_MUL0, B_MUL1, B_MUL2, B_THR,
      B_MAP, B_DIV_STEER, B_STEER, B_HIST, B_DIV_AVG, B_DONE
   } back_state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// ===== src/fvsd_front.sv =====
// Front end: accepts force vectors, flags range errors, two-entry queue
`timescale 1ns / 1ps
module fvsd_front import fvsd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [16:0] req_force_x,
   input  logic signed [16:0] req_force_y,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);

   item_type   slot_ff [2];
   item_type   item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      req_stall = (count_ff == 2'd2);
      push      = req_valid & ~req_stall;
      q_valid   = (count_ff != 2'd0);
      pop       = q_pop & q_valid;
      q_item    = slot_ff[rd_ptr_ff];
      item_in.x = req_force_x;
      item_in.y = req_force_y;
      item_in.err = (req_force_x > FORCE_LIMIT) || (req_force_x < -FORCE_LIMIT) ||
                    (req_force_y > FORCE_LIMIT) || (req_force_y < -FORCE_LIMIT);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== src/fvsd_back.sv =====
// Back end: square root, CORDIC angle, throttle scaling, steering map and averaging
`timescale 1ns / 1ps
module fvsd_back import fvsd_pkg::*; #(
   parameter int HISTORY_DEPTH = 8,
   parameter int ANGLE_BITS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic [7:0] rsp_throttle,
   output logic [7:0] rsp_steer,
   output logic       rsp_reversal
);

   localparam int AB    = ANGLE_BITS;
   localparam int SUM_W = $clog2(255 * HISTORY_DEPTH + 1);
   localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(int'(HIST_RESET) * HISTORY_DEPTH);
   // average by reciprocal multiply, exact over the whole sum range
   localparam int RECIP_SH = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam longint RECIP_VAL = ((longint'(1) << RECIP_SH) + longint'(HISTORY_DEPTH) - 1)
                                  / longint'(HISTORY_DEPTH);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   back_state_type     state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               err_ff, err_in;
   logic               neg_ff, neg_in;
   logic               axis_ff, axis_in;
   logic               sub_ff, sub_in;
   logic signed [19:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        sq_ff, sq_in;
   logic [31:0]        root_ff, root_in;
   logic signed [59:0] prod_ff, prod_in;
   logic [7:0]         drive_ff, drive_in;
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic [31:0]        den_ff, den_in;
   logic [7:0]         steer_new_ff, steer_new_in;
   logic [7:0]         hist_ff [HISTORY_DEPTH];
   logic [7:0]         hist_in [HISTORY_DEPTH];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [7:0]         last_thr_ff, last_thr_in;
   logic [7:0]         last_steer_ff, last_steer_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_throttle_ff, rsp_throttle_in;
   logic [7:0]         rsp_steer_ff, rsp_steer_in;
   logic               rsp_reversal_ff, rsp_reversal_in;

   logic signed [39:0] sqr;
   logic [31:0]        sbit, rtry;
   logic signed [19:0] dx, dy;
   logic [32:0]        mul0;
   logic [49:0]        mul1;
   logic signed [59:0] mul2, qv;
   logic signed [8:0]  nm1;
   logic signed [60:0] tot;
   logic [31:0]        accr;
   logic [AB:0]        a, t, half, full, num;
   logic [39:0]        tw, tsh;
   logic [31:0]        numprod;
   logic [32:0]        remsh;
   logic [31:0]        qsh;
   logic signed [33:0] tv;
   logic [SUM_W-1:0]   sum_new;
   logic [SUM_W+RECIP_W-1:0] avg_prod;
   logic [7:0]         avg_q;
   logic               rev;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_throttle = rsp_throttle_ff;
   assign rsp_steer    = rsp_steer_ff;
   assign rsp_reversal = rsp_reversal_ff;

   always_comb begin
      state_in = state_ff;  cnt_in = cnt_ff;  err_in = err_ff;  neg_in = neg_ff;
      axis_in = axis_ff;  sub_in = sub_ff;  x_in = x_ff;  y_in = y_ff;
      acc_in = acc_ff;  sq_in = sq_ff;  root_in = root_ff;  prod_in = prod_ff;
      drive_in = drive_ff;  rem_in = rem_ff;  quo_in = quo_ff;  den_in = den_ff;
      steer_new_in = steer_new_ff;  hist_in = hist_ff;  sum_in = sum_ff;
      last_thr_in = last_thr_ff;  last_steer_in = last_steer_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;  rsp_throttle_in = rsp_throttle_ff;
      rsp_steer_in = rsp_steer_ff;  rsp_reversal_in = rsp_reversal_ff;
      q_pop = 1'b0;

      sqr  = (state_ff == B_SQ0) ? x_ff * x_ff : y_ff * y_ff;
      sbit = TURN_QUARTER >> {cnt_ff[3:0], 1'b0};
      rtry = root_ff + sbit;
      dx   = y_ff >>> cnt_ff;
      dy   = x_ff >>> cnt_ff;
      mul0 = 33'(root_ff[15:0]) * 33'(neg_ff ? REV_SCALE : FWD_SCALE);
      mul1 = 50'(prod_ff[32:0]) * 50'(cfg.window);
      nm1  = $signed({1'b0, cfg.neutral}) - 9'sd1;
      mul2 = $signed({1'b0, prod_ff[49:0]}) * nm1;
      qv   = neg_ff ? ((-prod_ff) >>> 47) : (prod_ff >>> 47);
      tot  = $signed({qv[59], qv}) + $signed({53'd0, cfg.neutral});
      accr = acc_ff + (32'd1 << (31 - AB));
      a    = {1'b0, accr[31 -: AB]};
      tw   = {26'd0, cfg.turn} << 8;
      tsh  = tw >> (24 - AB);
      t    = (tsh[AB:0] == '0) ? (AB+1)'(1) : tsh[AB:0];
      half = (AB+1)'(1) << (AB - 1);
      full = (AB+1)'(1) << AB;
      num  = '0;
      remsh = {rem_ff[31:0], quo_ff[31]};
      qsh   = {quo_ff[30:0], 1'b0};
      tv    = sub_ff ? ($signed({26'd0, cfg.neutral}) - $signed({2'd0, quo_ff}))
                     : ($signed({26'd0, cfg.neutral}) + $signed({2'd0, quo_ff}));
      sum_new = sum_ff - hist_ff[HISTORY_DEPTH-1] + SUM_W'(steer_new_ff);
      avg_prod = (SUM_W+RECIP_W)'(sum_ff) * (SUM_W+RECIP_W)'(RECIP);
      avg_q    = avg_prod[RECIP_SH +: 8];
      rev = ((last_thr_ff > cfg.neutral) && (drive_ff < cfg.neutral)) ||
            ((last_thr_ff < cfg.neutral) && (drive_ff > cfg.neutral));

      if (a < t) begin
         num = a;  sub_in = 1'b0;
      end else if (a < half - t) begin
         num = '0;
      end else if (a < half) begin
         num = half - a;  sub_in = 1'b0;
      end else if (a < half + t) begin
         num = a - half;  sub_in = 1'b1;
      end else if (a < full - t) begin
         num = '0;
      end else begin
         num = full - a;  sub_in = 1'b1;
      end
      if (state_ff != B_MAP) begin
         sub_in = sub_ff;
      end
      numprod = 32'(num) * 32'(cfg.neutral);

      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               err_in = q_item.err;
               x_in   = 20'(q_item.x);
               y_in   = 20'(q_item.y);
               neg_in = q_item.x[16];
               state_in = q_item.err ? B_DONE : B_SQ0;
            end
         end
         B_SQ0: begin
            sq_in = sqr[31:0];
            state_in = B_SQ1;
         end
         B_SQ1: begin
            sq_in   = sq_ff + sqr[31:0];
            root_in = '0;
            cnt_in  = '0;
            if (y_ff == '0) begin
               axis_in = 1'b1;
               acc_in  = x_ff[19] ? TURN_HALF : '0;
            end else if (x_ff == '0) begin
               axis_in = 1'b1;
               acc_in  = y_ff[19] ? TURN_3QUARTER : TURN_QUARTER;
            end else begin
               axis_in = 1'b0;
               if (x_ff[19]) begin
                  x_in = -x_ff;  y_in = -y_ff;  acc_in = TURN_HALF;
               end else begin
                  acc_in = '0;
               end
            end
            state_in = B_ROT;
         end
         B_ROT: begin
            if (cnt_ff < SQRT_STEPS) begin
               if (sq_ff >= rtry) begin
                  sq_in   = sq_ff - rtry;
                  root_in = (root_ff >> 1) + sbit;
               end else begin
                  root_in = root_ff >> 1;
               end
            end
            if (!axis_ff) begin
               if (!y_ff[19]) begin
                  x_in = x_ff + dx;  y_in = y_ff - dy;
                  acc_in = acc_ff + atan_turn(cnt_ff);
               end else begin
                  x_in = x_ff - dx;  y_in = y_ff + dy;
                  acc_in = acc_ff - atan_turn(cnt_ff);
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CORDIC_LAST) begin
               state_in = B_MUL0;
            end
         end
         B_MUL0: begin
            prod_in = $signed({27'd0, mul0});
            state_in = B_MUL1;
         end
         B_MUL1: begin
            prod_in = $signed({10'd0, mul1});
            state_in = B_MUL2;
         end
         B_MUL2: begin
            prod_in = mul2;
            state_in = B_THR;
         end
         B_THR: begin
            if (tot < 0) begin
               drive_in = 8'd0;
            end else if (tot > 61'sd255) begin
               drive_in = 8'd255;
            end else begin
               drive_in = tot[7:0];
            end
            state_in = B_MAP;
         end
         B_MAP: begin
            if ((a >= t) && (a < half - t)) begin
               steer_new_in = cfg.smax;
               state_in = B_HIST;
            end else if ((a >= half + t) && (a < full - t)) begin
               steer_new_in = cfg.smin;
               state_in = B_HIST;
            end else begin
               quo_in = numprod;
               rem_in = '0;
               den_in = 32'(t);
               cnt_in = 5'd31;
               state_in = B_DIV_STEER;
            end
         end
         B_DIV_STEER: begin
            if (remsh >= {1'b0, den_ff}) begin
               rem_in = remsh - {1'b0, den_ff};
               quo_in = qsh | 32'd1;
            end else begin
               rem_in = remsh;
               quo_in = qsh;
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = B_STEER;
            end
         end
         B_STEER: begin
            if (tv < 0) begin
               steer_new_in = 8'd0;
            end else if (tv > 34'sd255) begin
               steer_new_in = 8'd255;
            end else begin
               steer_new_in = tv[7:0];
            end
            state_in = B_HIST;
         end
         B_HIST: begin
            hist_in[0] = steer_new_ff;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            sum_in = sum_new;
            state_in = B_DIV_AVG;
         end
         B_DIV_AVG: begin
            quo_in = 32'(avg_q);
            state_in = B_DONE;
         end
         B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_status_in   = 1'b1;
                  rsp_throttle_in = last_thr_ff;
                  rsp_steer_in    = last_steer_ff;
                  rsp_reversal_in = 1'b0;
               end else begin
                  rsp_status_in   = 1'b0;
                  rsp_throttle_in = drive_ff;
                  rsp_steer_in    = quo_ff[7:0];
                  rsp_reversal_in = rev;
                  last_thr_in     = drive_ff;
                  last_steer_in   = quo_ff[7:0];
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_thr_ff   <= 8'd0;
         last_steer_ff <= 8'd0;
         sum_ff        <= SUM_RESET;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= HIST_RESET;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_thr_ff   <= last_thr_in;
         last_steer_ff <= last_steer_in;
         sum_ff        <= sum_in;
         hist_ff       <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;  err_ff <= err_in;  neg_ff <= neg_in;  axis_ff <= axis_in;
      sub_ff <= sub_in;  x_ff <= x_in;  y_ff <= y_in;  acc_ff <= acc_in;
      sq_ff <= sq_in;  root_ff <= root_in;  prod_ff <= prod_in;  drive_ff <= drive_in;
      rem_ff <= rem_in;  quo_ff <= quo_in;  den_ff <= den_in;
      steer_new_ff <= steer_new_in;
      rsp_status_ff <= rsp_status_in;  rsp_throttle_ff <= rsp_throttle_in;
      rsp_steer_ff <= rsp_steer_in;  rsp_reversal_ff <= rsp_reversal_in;
   end

endmodule

// ===== src/force_vector_to_servo_drive.sv =====
// Top level: control registers, front queue and back-end sequencer
// Sequence: an out-of-range item goes from the queue straight to the result; an in-range
//   item passes the queue, squares, CORDIC with square root alongside, throttle scaling
//   and map, history average and output, with the band divide after the map when it runs.
// Items: one at a time in the back end, which returns to idle for the next once a result posts.
// Reset: synchronous; registers return to defaults, history fills with 128, queue empties.
`timescale 1ns / 1ps
module force_vector_to_servo_drive import fvsd_pkg::*; #(
   parameter int HISTORY_DEPTH = 8,
   parameter int ANGLE_BITS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [16:0] req_force_x,
   input  logic signed [16:0] req_force_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status,
   output logic [7:0]        rsp_throttle,
   output logic [7:0]        rsp_steer,
   output logic              rsp_reversal,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [16:0]       csr_data
);

   logic [16:0] window_ff;
   logic [13:0] turn_ff;
   logic [7:0]  neutral_ff, smin_ff, smax_ff;
   cfg_type     cfg;
   logic        q_valid, q_pop;
   item_type    q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg.window  = (window_ff > WINDOW_ONE) ? WINDOW_ONE : window_ff;
      cfg.turn    = turn_ff;
      cfg.neutral = neutral_ff;
      cfg.smin    = smin_ff;
      cfg.smax    = smax_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         turn_ff    <= TURN_RESET;
         neutral_ff <= NEUTRAL_RESET;
         smin_ff    <= MIN_RESET;
         smax_ff    <= MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW:  window_ff  <= csr_data;
            REG_TURN:    turn_ff    <= csr_data[13:0];
            REG_NEUTRAL: neutral_ff <= csr_data[7:0];
            REG_MIN:     smin_ff    <= csr_data[7:0];
            REG_MAX:     smax_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   fvsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_force_x (req_force_x),
      .req_force_y (req_force_y),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   fvsd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .ANGLE_BITS    (ANGLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_throttle (rsp_throttle),
      .rsp_steer    (rsp_steer),
      .rsp_reversal (rsp_reversal)
   );

endmodule

// ===== src/fvsd_checker.sv =====
// Port-level checker for the force vector servo drive, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fvsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_status,
   input logic [7:0] rsp_throttle,
   input logic       rsp_reversal
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_throttle))
   `ASSERT_CLK(a_err_no_rev, clock, reset, rsp_valid && rsp_status |-> !rsp_reversal)
   `ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind force_vector_to_servo_drive fvsd_checker u_fvsd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_throttle (rsp_throttle),
   .rsp_reversal (rsp_reversal)
);

// ===== tb/sv/force_vector_to_servo_drive_tb.sv =====
// Self-checking testbench for the force vector to servo drive block
`timescale 1ns / 1ps
module force_vector_to_servo_drive_tb import fvsd_pkg::*; ();

   typedef struct {
      bit       status;
      bit [7:0] throttle;
      bit [7:0] steer;
      bit       reversal;
   } drive_cmd_type;

   class drive_scoreboard_type;
      bit [16:0] window;
      bit [13:0] turn;
      bit [7:0]  neutral, smin, smax;
      bit [7:0]  history[8];
      bit [7:0]  last_throttle, last_steer;
      drive_cmd_type pending[$];
      int errors;

      function void clear();
         window = WINDOW_RESET;
         turn = TURN_RESET;
         neutral = NEUTRAL_RESET;
         smin = MIN_RESET;
         smax = MAX_RESET;
         foreach (history[i]) history[i] = HIST_RESET;
         last_throttle = 0;
         last_steer = 0;
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(bit [2:0] idx, bit [16:0] val);
         case (idx)
            REG_WINDOW:  window = val;
            REG_TURN:    turn = val[13:0];
            REG_NEUTRAL: neutral = val[7:0];
            REG_MIN:     smin = val[7:0];
            REG_MAX:     smax = val[7:0];
            default: ;
         endcase
      endfunction

      static function longint fl_shift(longint v, int s);
         return v >>> s;
      endfunction

      static function longint root(longint s);
         longint r, b;
         r = 0;
         b = 64'sd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      static function bit [31:0] atan_step(int i);
         bit [31:0] tbl[28] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005};
         return tbl[i];
      endfunction

      static function bit [15:0] heading(longint x, longint y);
         bit [31:0] acc;
         longint dx, dy;
         if (y == 0) acc = (x < 0) ? TURN_HALF : 32'd0;
         else if (x == 0) acc = (y > 0) ? TURN_QUARTER : TURN_3QUARTER;
         else begin
            acc = 0;
            if (x < 0) begin
               x = -x;
               y = -y;
               acc = TURN_HALF;
            end
            for (int i = 0; i < 28; i++) begin
               dx = fl_shift(y, i);
               dy = fl_shift(x, i);
               if (y >= 0) begin
                  x = x + dx;
                  y = y - dy;
                  acc = acc + atan_step(i);
               end else begin
                  x = x - dx;
                  y = y + dy;
                  acc = acc - atan_step(i);
               end
            end
         end
         acc = acc + 32'h8000;
         return acc[31:16];
      endfunction

      static function bit [7:0] clamp8(longint v);
         return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      endfunction

      function bit [7:0] steer_of(longint a);
         longint t, n;
         t = (turn == 0) ? 1 : turn;
         n = neutral;
         if (a < t) return clamp8(n + a * n / t);
         if (a < 32768 - t) return smax;
         if (a < 32768) return clamp8(n + (32768 - a) * n / t);
         if (a < 32768 + t) return clamp8(n - (a - 32768) * n / t);
         if (a < 65536 - t) return smin;
         return clamp8(n - (65536 - a) * n / t);
      endfunction

      function void note_force(bit signed [16:0] fx, bit signed [16:0] fy);
         drive_cmd_type e;
         longint x, y, n, p, q, mag, win, sum;
         x = fx;
         y = fy;
         if (x > 32768 || x < -32768 || y > 32768 || y < -32768) begin
            e = '{1'b1, last_throttle, last_steer, 1'b0};
            pending.push_back(e);
            return;
         end
         n = neutral;
         mag = root(x * x + y * y);
         win = (window > 65536) ? 65536 : window;
         p = (n - 1) * win * mag;
         q = (x < 0) ? fl_shift(-p * 52429, 47) : fl_shift(p, 31);
         e.status = 0;
         e.throttle = clamp8(n + q);
         e.reversal = (last_throttle > n && e.throttle < n) ||
                      (last_throttle < n && e.throttle > n);
         for (int i = 7; i > 0; i--) history[i] = history[i-1];
         history[0] = steer_of(heading(x, y));
         sum = 0;
         foreach (history[i]) sum += history[i];
         e.steer = 8'(sum / 8);
         last_throttle = e.throttle;
         last_steer = e.steer;
         pending.push_back(e);
      endfunction

      function void check_cmd(drive_cmd_type got);
         drive_cmd_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected transfer status=%0d throttle=%0d steer=%0d rev=%0d",
                     $time, got.status, got.throttle, got.steer, got.reversal);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status != e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.throttle != e.throttle) begin
            $display("%0t: throttle expected %0d actual %0d", $time, e.throttle, got.throttle);
            errors++;
         end
         if (got.steer != e.steer) begin
            $display("%0t: steer expected %0d actual %0d", $time, e.steer, got.steer);
            errors++;
         end
         if (got.reversal != e.reversal) begin
            $display("%0t: reversal expected %0d actual %0d", $time, e.reversal, got.reversal);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [16:0] req_force_x = 0, req_force_y = 0;
   logic rsp_valid, rsp_stall = 0, rsp_status, rsp_reversal;
   logic [7:0] rsp_throttle, rsp_steer;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [16:0] csr_data = 0;
   longint cycles = 0;
   bit stim_done = 0;
   drive_scoreboard_type sb;

   force_vector_to_servo_drive dut (.*);

   always #6 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   always @(posedge clock) begin
      drive_cmd_type got;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_throttle, rsp_steer, rsp_reversal};
         sb.check_cmd(got);
      end
      if (cycles > 4000000) begin
         $display("force_vector_to_servo_drive: mismatch");
         $finish;
      end
   end

   initial begin
      int g;
      @(negedge clock);
      while (!stim_done || sb.pending.size() != 0) begin
         g = gap_len();
         rsp_stall <= (g != 0);
         repeat (g > 0 ? g : 1) @(negedge clock);
         if (g != 0) begin
            rsp_stall <= 0;
            @(negedge clock);
         end
      end
      rsp_stall <= 0;
   end

   task automatic send_force(logic signed [16:0] fx, logic signed [16:0] fy);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_force_x <= fx;
      req_force_y <= fy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_force(fx, fy);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [16:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (100) @(negedge clock);
   endtask

   function automatic logic signed [16:0] rand_force();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 17'($signed($urandom_range(0, 65536)) - 32768);
      if (r < 88) return $urandom_range(0, 1) ? 17'sd32768 : -17'sd32768;
      if (r < 93) return 17'sd0;
      return 17'($urandom());
   endfunction

   task automatic set_config(int k);
      case (k)
         0: begin
            write_reg(REG_WINDOW, WINDOW_ONE);
            write_reg(REG_TURN, 17'd1);
            write_reg(REG_NEUTRAL, 17'd1);
            write_reg(REG_MIN, 17'd255);
            write_reg(REG_MAX, 17'd0);
         end
         1: begin
            write_reg(REG_WINDOW, 17'd0);
            write_reg(REG_TURN, 17'd16383);
            write_reg(REG_NEUTRAL, 17'd128);
            write_reg(REG_MIN, 17'd0);
            write_reg(REG_MAX, 17'd255);
         end
         2: begin
            write_reg(REG_WINDOW, 17'h1FFFF);
            write_reg(REG_TURN, 17'd0);
            write_reg(REG_NEUTRAL, 17'd255);
         end
         3: begin
            write_reg(REG_NEUTRAL, 17'd0);
            write_reg(REG_TURN, 17'd16383);
         end
         default: begin
            write_reg(REG_WINDOW, 17'($urandom_range(0, 65536)));
            write_reg(REG_TURN, 17'($urandom_range(1, 16383)));
            write_reg(REG_NEUTRAL, 17'($urandom_range(1, 128)));
            write_reg(REG_MIN, 17'($urandom_range(0, 255)));
            write_reg(REG_MAX, 17'($urandom_range(0, 255)));
         end
      endcase
      csr_valid <= 0;
   endtask

   initial begin
      sb = new();
      sb.clear();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (2) @(negedge clock);
      send_force(17'sd0, 17'sd0);
      send_force(17'sd32768, 17'sd0);
      send_force(-17'sd32768, 17'sd0);
      send_force(17'sd0, 17'sd32768);
      send_force(17'sd0, -17'sd32768);
      send_force(17'sd32768, 17'sd32768);
      send_force(-17'sd32768, -17'sd32768);
      send_force(-17'sd32768, 17'sd32768);
      send_force(17'sd32768, -17'sd32768);
      send_force(17'sd32769, 17'sd0);
      send_force(17'sd0, -17'sd32769);
      send_force(17'sd65535, 17'sh10000);
      send_force(17'sh10000, 17'sd65535);
      send_force(17'sd1, 17'sd1);
      send_force(-17'sd1, -17'sd1);
      send_force(17'sd30000, 17'sd200);
      send_force(-17'sd30000, 17'sd200);
      send_force(17'sd200, 17'sd30000);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         set_config(ph);
         repeat (190) send_force(rand_force(), rand_force());
         drain();
      end
      stim_done = 1;
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("force_vector_to_servo_drive: match");
      else
         $display("force_vector_to_servo_drive: mismatch");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+src
src/fvsd_pkg.sv
src/fvsd_front.sv
src/fvsd_back.sv
src/force_vector_to_servo_drive.sv
src/fvsd_checker.sv
tb/sv/force_vector_to_servo_drive_tb.sv
